/* src/zfwc_pkg.sv */
// ----------------------------------------------------------------------------
// zfwc_pkg
// shared types, codes and helper functions for the zlib frame wrap/check block
// ----------------------------------------------------------------------------
package zfwc_pkg;

  localparam int unsigned MaxRes = 6;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  localparam logic [16:0] AdlerMod  = 17'd65521;
  localparam logic [7:0]  HdrCmf    = 8'h78;
  localparam logic [7:0]  HdrFlg    = 8'h9c;
  localparam logic [31:0] MinStream = 32'd6;
  localparam logic [3:0]  CmMethod  = 4'd8;

  // item kind codes
  localparam logic [1:0] KindData   = 2'd0;
  localparam logic [1:0] KindStream = 2'd1;
  localparam logic [1:0] KindEnd    = 2'd2;

  // configuration register indexes
  localparam logic CfgMode    = 1'b0;
  localparam logic CfgExpSize = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_PRESET    = 3'd3,
    ST_SIZE      = 3'd4,
    ST_ADLER     = 3'd5
  } status_e;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   is_status;
    status_e                status;
    logic                   last;
  } burst_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
  } adler_t;

  function automatic logic [15:0] adler_fold(logic [16:0] v);
    logic [16:0] r;
    r = (v >= AdlerMod) ? (v - AdlerMod) : v;
    return r[15:0];
  endfunction

  function automatic adler_t adler_step(adler_t a, logic [7:0] b);
    adler_t n;
    n.low  = adler_fold({1'b0, a.low} + 17'(b));
    n.high = adler_fold({1'b0, a.high} + {1'b0, n.low});
    return n;
  endfunction

  // cmf*256+flg multiple of 31, by folding 5-bit digits (32 = 1 mod 31)
  function automatic logic fcheck_ok(logic [7:0] cmf, logic [7:0] flg);
    logic [15:0] v;
    logic [6:0]  s1;
    logic [5:0]  s2;
    v  = {cmf, flg};
    s1 = 7'(v[4:0]) + 7'(v[9:5]) + 7'(v[14:10]) + 7'(v[15]);
    s2 = 6'(s1[4:0]) + 6'(s1[6:5]);
    return (s2 == 6'd0) || (s2 == 6'd31);
  endfunction

endpackage

/* src/zfwc_state.sv */
// ----------------------------------------------------------------------------
// zfwc_state
// job state, adler-32 update and per-request result burst decode
// ----------------------------------------------------------------------------
module zfwc_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic [31:0]      exp_size_i,
  input  logic             fire_i,
  input  logic [1:0]       kind_i,
  input  logic [7:0]       byte_i,
  output logic             has_res_o,
  output zfwc_pkg::burst_t burst_o
);
  import zfwc_pkg::*;

  adler_t      adler_q, adler_d;
  logic [31:0] scnt_q, scnt_d;
  logic [31:0] dcnt_q, dcnt_d;
  logic [7:0]  cmf_q, cmf_d;
  logic [7:0]  flg_q, flg_d;
  logic [31:0] tail_q, tail_d;
  logic        hsent_q, hsent_d;

  adler_t      adler_nx;
  logic [31:0] adler_word;
  status_e     verdict;

  assign adler_nx   = adler_step(adler_q, byte_i);
  assign adler_word = {adler_q.high, adler_q.low};

  always_comb begin
    if (scnt_q < MinStream) begin
      verdict = ST_TOO_SMALL;
    end else if ((cmf_q[3:0] != CmMethod) || !fcheck_ok(cmf_q, flg_q)) begin
      verdict = ST_BAD_HDR;
    end else if (flg_q[5]) begin
      verdict = ST_PRESET;
    end else if (dcnt_q != exp_size_i) begin
      verdict = ST_SIZE;
    end else if (adler_word != tail_q) begin
      verdict = ST_ADLER;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    adler_d   = adler_q;
    scnt_d    = scnt_q;
    dcnt_d    = dcnt_q;
    cmf_d     = cmf_q;
    flg_d     = flg_q;
    tail_d    = tail_q;
    hsent_d   = hsent_q;
    has_res_o = 1'b0;
    burst_o   = '0;
    case (kind_i)
      KindData: begin
        adler_d = adler_nx;
        if (mode_i && (dcnt_q != '1)) begin
          dcnt_d = dcnt_q + 32'd1;
        end
      end
      KindStream: begin
        if (!mode_i) begin
          has_res_o = 1'b1;
          hsent_d   = 1'b1;
          if (!hsent_q) begin
            burst_o.bytes[0] = HdrCmf;
            burst_o.bytes[1] = HdrFlg;
            burst_o.bytes[2] = byte_i;
            burst_o.cnt      = CntW'(3);
          end else begin
            burst_o.bytes[0] = byte_i;
            burst_o.cnt      = CntW'(1);
          end
        end else begin
          if (scnt_q == 32'd0) begin
            cmf_d = byte_i;
          end else if (scnt_q == 32'd1) begin
            flg_d = byte_i;
          end
          tail_d = {tail_q[23:0], byte_i};
          if (scnt_q != '1) begin
            scnt_d = scnt_q + 32'd1;
          end
        end
      end
      KindEnd: begin
        has_res_o    = 1'b1;
        burst_o.last = 1'b1;
        if (!mode_i) begin
          if (!hsent_q) begin
            burst_o.bytes[0] = HdrCmf;
            burst_o.bytes[1] = HdrFlg;
            burst_o.bytes[2] = adler_word[31:24];
            burst_o.bytes[3] = adler_word[23:16];
            burst_o.bytes[4] = adler_word[15:8];
            burst_o.bytes[5] = adler_word[7:0];
            burst_o.cnt      = CntW'(6);
          end else begin
            burst_o.bytes[0] = adler_word[31:24];
            burst_o.bytes[1] = adler_word[23:16];
            burst_o.bytes[2] = adler_word[15:8];
            burst_o.bytes[3] = adler_word[7:0];
            burst_o.cnt      = CntW'(4);
          end
        end else begin
          burst_o.cnt       = CntW'(1);
          burst_o.is_status = 1'b1;
          burst_o.status    = verdict;
        end
        adler_d.low  = 16'd1;
        adler_d.high = 16'd0;
        scnt_d       = '0;
        dcnt_d       = '0;
        cmf_d        = '0;
        flg_d        = '0;
        tail_d       = '0;
        hsent_d      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adler_q.low  <= 16'd1;
      adler_q.high <= 16'd0;
      scnt_q       <= '0;
      dcnt_q       <= '0;
      cmf_q        <= '0;
      flg_q        <= '0;
      tail_q       <= '0;
      hsent_q      <= 1'b0;
    end else if (fire_i) begin
      adler_q <= adler_d;
      scnt_q  <= scnt_d;
      dcnt_q  <= dcnt_d;
      cmf_q   <= cmf_d;
      flg_q   <= flg_d;
      tail_q  <= tail_d;
      hsent_q <= hsent_d;
    end
  end

endmodule

/* src/zfwc_burst.sv */
// ----------------------------------------------------------------------------
// zfwc_burst
// result burst register and beat sequencer towards the output stream
// ----------------------------------------------------------------------------
module zfwc_burst (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  zfwc_pkg::burst_t burst_i,
  output logic             free_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic             m_axis_tuser,   // [0] is_status
  output logic             m_axis_tlast
);
  import zfwc_pkg::*;

  burst_t          burst_q;
  logic            busy_q;
  logic [IdxW-1:0] idx_q;
  logic            beat_last;

  assign beat_last = (idx_q == IdxW'(burst_q.cnt - CntW'(1)));
  assign free_o    = !busy_q || (beat_last && m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && m_axis_tready) begin
      if (beat_last) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {5'd0, burst_q.status, burst_q.bytes[idx_q]};
  assign m_axis_tuser  = burst_q.is_status;
  assign m_axis_tlast  = burst_q.last && beat_last;

endmodule

/* src/zlib_frame_wrap_check_core.sv */
// ----------------------------------------------------------------------------
// zlib_frame_wrap_check_core
// zlib wrapper: header/adler-32 trailer framing, or stream check with verdict
// ----------------------------------------------------------------------------
//  channel   | direction | tdata                         | tuser       | tlast
//  s_axis    | in        | [7:0] byte_value              | [1:0] kind  | -
//  m_axis    | out       | [7:0] out_byte, [10:8] status | [0] is_stat | last
//  cfg       | in        | cfg_wdata_i, index cfg_idx_i  | -           | -
//
//  while not stalled, one request per cycle enters the input register; from
//  there it updates the job state and loads its result burst into the output
//  register; a burst of n results leaves at one beat per cycle while not
//  stalled, and a request with results waits for the burst ahead to drain;
//  requests with no result never wait; rst_ni clears the job state,
//  configuration and both registers; m_axis_tready low stalls the burst and,
//  once a request with results waits in the input register, s_axis_tready
// ----------------------------------------------------------------------------
module zlib_frame_wrap_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import zfwc_pkg::*;

  logic        mode_q;
  logic [31:0] exp_size_q;
  logic        in_valid_q;
  logic [1:0]  in_kind_q;
  logic [7:0]  in_byte_q;
  logic        has_res;
  logic        burst_free;
  logic        take;
  burst_t      burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      exp_size_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMode:    mode_q     <= cfg_wdata_i[0];
        CfgExpSize: exp_size_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign take          = in_valid_q && (!has_res || burst_free);
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  zfwc_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (mode_q),
    .exp_size_i (exp_size_q),
    .fire_i     (take),
    .kind_i     (in_kind_q),
    .byte_i     (in_byte_q),
    .has_res_o  (has_res),
    .burst_o    (burst)
  );

  zfwc_burst u_burst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && has_res),
    .burst_i       (burst),
    .free_o        (burst_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("verdict not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[10:8] == 3'd0)
    else $error("status set on a stream byte");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[10:8] <= 3'd5)
    else $error("malformed verdict");

endmodule

/* bench/zlib_frame_wrap_check_core_tb.sv */
// ----------------------------------------------------------------------------
// zlib_frame_wrap_check_core_tb
// self-checking bench for the zlib frame wrapper and stream checker
//
// directed requests cover header and trailer framing, the too-small and OK
// verdicts, the ignored kind code and a mode change in the middle of a job.
// Then random jobs: compress jobs of mixed bytes, and check jobs built as
// well-formed zlib streams with at most one fault injected at random. A
// predictor in the bench keeps its own job state and queues the expected
// output beats, and a monitor compares every accepted beat field by field.
// ----------------------------------------------------------------------------
module zlib_frame_wrap_check_core_tb;
  import zfwc_pkg::*;

  localparam logic [1:0] KindNone = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    status_e    status;
    logic       last;
  } beat_t;

  typedef enum int {
    FLT_NONE, FLT_SHORT, FLT_METHOD, FLT_FCHECK, FLT_DICT, FLT_SIZE, FLT_ADLER
  } fault_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic [1:0]  s_axis_tuser  = KindData;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = CfgMode;
  logic [31:0] cfg_wdata_i   = 32'h0;

  // bench copy of the registers and job state
  logic        reg_mode = 1'b0;
  logic [31:0] reg_size = 32'h0;
  logic [15:0] sum_lo   = 16'd1;
  logic [15:0] sum_hi   = 16'd0;
  logic [31:0] strm_cnt = '0;
  logic [31:0] data_cnt = '0;
  logic [7:0]  cmf_q    = '0;
  logic [7:0]  flg_q    = '0;
  logic [31:0] tail_q   = '0;
  logic        hdr_sent = 1'b0;

  beat_t       framed_q[$];
  int unsigned err_cnt  = 0;
  int unsigned item_cnt = 0;
  bit          gaps_on  = 1'b1;

  zlib_frame_wrap_check_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] byte_value
    .s_axis_tuser (s_axis_tuser),   // [1:0] kind
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [7:0] out_byte, [10:8] status
    .m_axis_tuser (m_axis_tuser),   // [0] is_status
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5000000;
    $display("zlib_frame_wrap_check_core regression: fail");
    $finish;
  end

  task automatic report_err(string what);
    if (err_cnt < 50) $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // ---- predictor ----
  function automatic void clear_job();
    sum_lo   = 16'd1;
    sum_hi   = 16'd0;
    strm_cnt = '0;
    data_cnt = '0;
    cmf_q    = '0;
    flg_q    = '0;
    tail_q   = '0;
    hdr_sent = 1'b0;
  endfunction

  function automatic void adler_add(logic [7:0] b);
    logic [16:0] acc;
    acc = {1'b0, sum_lo} + 17'(b);
    if (acc >= AdlerMod) acc = acc - AdlerMod;
    sum_lo = acc[15:0];
    acc = {1'b0, sum_hi} + {1'b0, sum_lo};
    if (acc >= AdlerMod) acc = acc - AdlerMod;
    sum_hi = acc[15:0];
  endfunction

  function automatic void push_beat(logic [7:0] b, logic is_st, status_e st, logic lst);
    beat_t bt;
    bt.out_byte  = b;
    bt.is_status = is_st;
    bt.status    = st;
    bt.last      = lst;
    framed_q.insert(framed_q.size(), bt);
  endfunction

  function automatic status_e job_verdict();
    if (strm_cnt < MinStream) return ST_TOO_SMALL;
    if (cmf_q[3:0] != CmMethod || ({cmf_q, flg_q} % 31) != 0) return ST_BAD_HDR;
    if (flg_q[5]) return ST_PRESET;
    if (data_cnt != reg_size) return ST_SIZE;
    if ({sum_hi, sum_lo} != tail_q) return ST_ADLER;
    return ST_OK;
  endfunction

  function automatic void wrap_check_step(logic [1:0] kind, logic [7:0] b);
    logic [31:0] adler;
    adler = {sum_hi, sum_lo};
    if (kind == KindNone) return;
    if (!reg_mode) begin
      if (kind != KindData && !hdr_sent) begin
        push_beat(HdrCmf, 1'b0, ST_OK, 1'b0);
        push_beat(HdrFlg, 1'b0, ST_OK, 1'b0);
        hdr_sent = 1'b1;
      end
      case (kind)
        KindData: adler_add(b);
        KindStream: push_beat(b, 1'b0, ST_OK, 1'b0);
        default: begin
          push_beat(adler[31:24], 1'b0, ST_OK, 1'b0);
          push_beat(adler[23:16], 1'b0, ST_OK, 1'b0);
          push_beat(adler[15:8], 1'b0, ST_OK, 1'b0);
          push_beat(adler[7:0], 1'b0, ST_OK, 1'b1);
          clear_job();
        end
      endcase
    end else begin
      case (kind)
        KindData: begin
          adler_add(b);
          if (data_cnt != '1) data_cnt++;
        end
        KindStream: begin
          if (strm_cnt == 0) cmf_q = b;
          else if (strm_cnt == 1) flg_q = b;
          tail_q = {tail_q[23:0], b};
          if (strm_cnt != '1) strm_cnt++;
        end
        default: begin
          push_beat(8'h00, 1'b1, job_verdict(), 1'b1);
          clear_job();
        end
      endcase
    end
  endfunction

  // ---- output side: stalls and checking ----
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 1) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : beat_check
    beat_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (framed_q.size() == 0) begin
        report_err($sformatf("beat with nothing pending, tdata %h", m_axis_tdata));
      end else begin
        want = framed_q.pop_front();
        if (m_axis_tdata[7:0] !== want.out_byte)
          report_err($sformatf("out_byte %h, want %h", m_axis_tdata[7:0], want.out_byte));
        if (m_axis_tuser !== want.is_status)
          report_err($sformatf("is_status %b, want %b", m_axis_tuser, want.is_status));
        if (m_axis_tdata[10:8] !== want.status)
          report_err($sformatf("status %0d, want %0d", m_axis_tdata[10:8], want.status));
        if (m_axis_tlast !== want.last)
          report_err($sformatf("last %b, want %b", m_axis_tlast, want.last));
        if (m_axis_tdata[15:11] !== 5'd0)
          report_err($sformatf("tdata pad bits %b", m_axis_tdata[15:11]));
      end
    end
  end

  // ---- input side ----
  task automatic send_item(logic [1:0] kind, logic [7:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    wrap_check_step(kind, b);
    if (kind != KindNone) item_cnt++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMode) reg_mode = val[0];
    else reg_size = val;
  endtask

  // ---- job builders ----
  task automatic run_compress_job();
    if (reg_mode != 1'b0) write_reg(CfgMode, 32'd0);
    repeat ($urandom_range(0, 14)) begin
      case ($urandom_range(0, 8))
        0:       send_item(KindNone, 8'($urandom));
        1, 2, 3: send_item(KindStream, 8'($urandom));
        default: send_item(KindData, 8'($urandom));
      endcase
    end
    send_item(KindEnd, 8'($urandom));
  endtask

  task automatic run_check_job(fault_e fault);
    logic [7:0]  data_b[$];
    logic [7:0]  strm_b[$];
    int unsigned a_lo, a_hi, n_keep;
    logic [7:0]  cmf, flg;
    logic [31:0] trailer, size_v;
    a_lo = 1;
    a_hi = 0;
    repeat ($urandom_range(0, 12)) data_b.insert(data_b.size(), 8'($urandom));
    foreach (data_b[i]) begin
      a_lo = (a_lo + data_b[i]) % AdlerMod;
      a_hi = (a_hi + a_lo) % AdlerMod;
    end
    cmf = {4'($urandom), CmMethod};
    if (fault == FLT_METHOD) cmf[3:0] = CmMethod ^ 4'($urandom_range(1, 15));
    flg = {3'($urandom), 5'd0};
    flg[5] = (fault == FLT_DICT);
    flg[4:0] = 5'((31 - ({cmf, flg} % 31)) % 31);
    if (fault == FLT_FCHECK) flg[0] = ~flg[0];
    trailer = {a_hi[15:0], a_lo[15:0]};
    if (fault == FLT_ADLER) trailer = trailer ^ (32'd1 << $urandom_range(0, 31));
    strm_b.insert(strm_b.size(), cmf);
    strm_b.insert(strm_b.size(), flg);
    repeat ($urandom_range(0, 8)) strm_b.insert(strm_b.size(), 8'($urandom));
    for (int k = 3; k >= 0; k--) strm_b.insert(strm_b.size(), trailer[8*k +: 8]);
    if (fault == FLT_SHORT) begin
      n_keep = $urandom_range(0, 5);
      while (strm_b.size() > n_keep) void'(strm_b.pop_back());
    end
    size_v = data_b.size();
    if (fault == FLT_SIZE)
      size_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : size_v + $urandom_range(1, 1000);
    if (reg_mode != 1'b1) write_reg(CfgMode, 32'd1);
    write_reg(CfgExpSize, size_v);
    while (data_b.size() + strm_b.size() != 0) begin
      if ($urandom_range(0, 15) == 0) send_item(KindNone, 8'($urandom));
      if (strm_b.size() != 0 && (data_b.size() == 0 || $urandom_range(0, 1)))
        send_item(KindStream, strm_b.pop_front());
      else
        send_item(KindData, data_b.pop_front());
    end
    send_item(KindEnd, 8'($urandom));
  endtask

  // ---- tests ----
  task automatic test_compress_framing();
    write_reg(CfgMode, 32'd0);
    send_item(KindEnd, 8'hFF);
    send_item(KindData, 8'h00);
    send_item(KindData, 8'hFF);
    send_item(KindNone, 8'h5A);
    send_item(KindStream, 8'h00);
    send_item(KindStream, 8'hFF);
    send_item(KindData, 8'h80);
    send_item(KindEnd, 8'h00);
  endtask

  task automatic test_check_verdicts();
    write_reg(CfgMode, 32'd1);
    write_reg(CfgExpSize, 32'd0);
    send_item(KindEnd, 8'h00);
    send_item(KindStream, HdrCmf);
    send_item(KindStream, HdrFlg);
    send_item(KindStream, 8'h00);
    send_item(KindStream, 8'h00);
    send_item(KindStream, 8'h00);
    send_item(KindStream, 8'h01);
    send_item(KindEnd, 8'hA5);
  endtask

  task automatic test_mode_switch();
    write_reg(CfgMode, 32'd0);
    send_item(KindData, 8'h41);
    send_item(KindStream, 8'h12);
    write_reg(CfgMode, 32'd1);
    send_item(KindStream, 8'h34);
    send_item(KindData, 8'h42);
    write_reg(CfgMode, 32'd0);
    send_item(KindEnd, 8'h00);
  endtask

  task automatic test_random_jobs(int unsigned n_items);
    int unsigned stop_at;
    fault_e      f;
    stop_at = item_cnt + n_items;
    while (item_cnt < stop_at) begin
      if ($urandom_range(0, 2) == 0) begin
        run_compress_job();
      end else begin
        f = ($urandom_range(0, 1) == 0) ? FLT_NONE : fault_e'($urandom_range(1, 6));
        run_check_job(f);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_compress_framing();
    test_check_verdicts();
    test_mode_switch();
    test_random_jobs(260);
    gaps_on = 1'b0;
    test_random_jobs(60);
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("zlib_frame_wrap_check_core regression: pass");
    end else begin
      $display("zlib_frame_wrap_check_core regression: fail");
    end
    $finish;
  end

endmodule
